// File: sv/multi_mode_axis_reducer_top_macros.svh
// ----------------------------------------------------------------------------
// multi_mode_axis_reducer_top_macros
// Assertion macros shared by the reducer RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_AXIS_REDUCER_TOP_MACROS_SVH
`define MULTI_MODE_AXIS_REDUCER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MMAR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MMAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mmar_pkg.sv
// ----------------------------------------------------------------------------
// mmar_pkg
// Types and constants of the multi-mode axis reducer.
// ----------------------------------------------------------------------------
package mmar_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int MAX_INNER_DEF  = 1024;
    localparam int MODE_W         = 3;
    localparam int RLEN_W         = 16;
    localparam int ILEN_W         = 11;
    localparam int CFG_AW         = 2;
    localparam int CFG_DW         = 16;

    localparam logic [MODE_W-1:0] MODE_SUM  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SSQ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PROD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MEAN = 3'd5;

    localparam logic [CFG_AW-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_AW-1:0] REG_REDUCE_LEN = 2'd1;
    localparam logic [CFG_AW-1:0] REG_INNER_LEN  = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] dividend;
        logic [RLEN_W-1:0]     divisor;
        logic                  last;
    } mmar_div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  valid;
        logic [DATA_WIDTH-1:0] quotient;
        logic                  last;
    } mmar_div_rsp_t;

endpackage

// File: sv/mmar_partials.sv
// ----------------------------------------------------------------------------
// mmar_partials
// Partial accumulator store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmar_partials
    import mmar_pkg::*;
#(
    parameter int DEPTH = MAX_INNER_DEF,
    parameter int AW    = 10
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/mmar_div.sv
// ----------------------------------------------------------------------------
// mmar_div
// Signed by unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmar_div
    import mmar_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  mmar_div_req_t req,
    input  logic          ack,
    output mmar_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [RLEN_W-1:0]     rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [RLEN_W-1:0]     dvs_reg, dvs_next;
    logic                  neg_reg, neg_next;
    logic                  last_reg, last_next;
    logic [RLEN_W:0]       trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        last_next = last_reg;
        if (done_reg && ack) begin
            done_next = 1'b0;
        end
        if (req.valid) begin
            run_next  = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            neg_next  = req.dividend[DATA_WIDTH-1];
            quo_next  = req.dividend[DATA_WIDTH-1] ? (~req.dividend + 1'b1) : req.dividend;
            dvs_next  = req.divisor;
            last_next = req.last;
        end else if (run_reg) begin
            rem_next = fits ? RLEN_W'(trial - {1'b0, dvs_reg}) : trial[RLEN_W-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        last_reg <= last_next;
    end

    assign rsp.busy     = run_reg || done_reg;
    assign rsp.valid    = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.last     = last_reg;

endmodule

// File: sv/multi_mode_axis_reducer_top.sv
// ----------------------------------------------------------------------------
// multi_mode_axis_reducer_top: beats pass the combine and output registers, with
// the 32-step divider between them in mean mode; one beat per cycle (partials
// read-modify-write) unless output or divider stalls; mean: one per divider pass.
// Reset clears positions and sets mode 0, reduce_len 1, inner_len 1; no clear.
// ----------------------------------------------------------------------------
module multi_mode_axis_reducer_top
    import mmar_pkg::*;
#(
    parameter int MAX_INNER = MAX_INNER_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_DW-1:0]     cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // [31:0] value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_WIDTH-1:0] m_axis_tdata,   // [31:0] reduced
    output logic                  m_axis_tlast
);

`include "multi_mode_axis_reducer_top_macros.svh"

    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW = $clog2(MAX_INNER + 1);

    logic [MODE_W-1:0]     mode_reg;
    logic [RLEN_W-1:0]     rl_reg;
    logic [CW-1:0]         il_reg;
    logic [CW-1:0]         il_cfg;
    logic [RLEN_W-1:0]     rpos_reg, rpos_next;
    logic [IW-1:0]         ipos_reg, ipos_next;

    logic                  accept;
    logic                  last_inner, last_reduce;
    logic [DATA_WIDTH-1:0] v_in;

    logic                  b_valid_reg;
    logic [DATA_WIDTH-1:0] b_v_reg;
    logic [IW-1:0]         b_ip_reg;
    logic                  b_first_reg, b_lr_reg, b_li_reg, b_fwd_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;
    logic                  b_go;
    logic [DATA_WIDTH-1:0] p_val, comb, acc;
    logic                  is_mean;

    logic [DATA_WIDTH-1:0] rd_data;
    logic                  mem_wr_en;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_free, b_out_load, div_ack;

    mmar_div_req_t         div_req;
    mmar_div_rsp_t         div_rsp;

    // configuration
    always_comb begin
        if (cfg_wr_data[ILEN_W-1:0] == '0) begin
            il_cfg = CW'(1);
        end else if (32'(cfg_wr_data[ILEN_W-1:0]) > MAX_INNER) begin
            il_cfg = CW'(MAX_INNER);
        end else begin
            il_cfg = CW'(cfg_wr_data[ILEN_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SUM;
            rl_reg   <= RLEN_W'(1);
            il_reg   <= CW'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MODE:       mode_reg <= cfg_wr_data[MODE_W-1:0];
                REG_REDUCE_LEN: rl_reg   <= (cfg_wr_data == '0) ? RLEN_W'(1) : cfg_wr_data;
                REG_INNER_LEN:  il_reg   <= il_cfg;
                default: ;
            endcase
        end
    end

    // position tracking
    assign is_mean     = mode_reg == MODE_MEAN;
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign last_inner  = (CW'(ipos_reg) + 1'b1) == il_reg;
    assign last_reduce = ({1'b0, rpos_reg} + 1'b1) == {1'b0, rl_reg};
    assign v_in        = (mode_reg == MODE_SSQ) ? (s_axis_tdata * s_axis_tdata) : s_axis_tdata;

    always_comb begin
        rpos_next = rpos_reg;
        ipos_next = ipos_reg;
        if (cfg_wr_en && (cfg_addr == REG_MODE || cfg_addr == REG_REDUCE_LEN
                          || cfg_addr == REG_INNER_LEN)) begin
            rpos_next = '0;
            ipos_next = '0;
        end else if (accept) begin
            if (last_inner) begin
                ipos_next = '0;
                rpos_next = last_reduce ? '0 : rpos_reg + 1'b1;
            end else begin
                ipos_next = ipos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpos_reg <= '0;
            ipos_reg <= '0;
        end else begin
            rpos_reg <= rpos_next;
            ipos_reg <= ipos_next;
        end
    end

    // combine stage
    assign p_val = b_fwd_reg ? fwd_data_reg : rd_data;

    always_comb begin
        unique case (mode_reg)
            MODE_PROD: comb = p_val * b_v_reg;
            MODE_MIN:  comb = ($signed(b_v_reg) < $signed(p_val)) ? b_v_reg : p_val;
            MODE_MAX:  comb = ($signed(p_val) < $signed(b_v_reg)) ? b_v_reg : p_val;
            default:   comb = p_val + b_v_reg;
        endcase
        acc = b_first_reg ? b_v_reg : comb;
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb begin
        if (!b_valid_reg) begin
            b_go = 1'b0;
        end else if (!b_lr_reg) begin
            b_go = 1'b1;
        end else if (is_mean) begin
            b_go = !div_rsp.busy;
        end else begin
            b_go = out_free && !div_rsp.valid;
        end
    end

    assign s_axis_tready = !b_valid_reg || b_go;
    assign mem_wr_en     = b_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_go) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_v_reg     <= v_in;
            b_ip_reg    <= ipos_reg;
            b_first_reg <= rpos_reg == '0;
            b_lr_reg    <= last_reduce;
            b_li_reg    <= last_inner;
            b_fwd_reg   <= b_go && (b_ip_reg == ipos_reg);
        end
        if (b_go) begin
            fwd_data_reg <= acc;
        end
    end

    mmar_partials #(
        .DEPTH (MAX_INNER),
        .AW    (IW)
    ) u_partials (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (ipos_reg),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (b_ip_reg),
        .wr_data (acc)
    );

    // mean divider
    assign div_req.valid    = b_go && b_lr_reg && is_mean;
    assign div_req.dividend = acc;
    assign div_req.divisor  = rl_reg;
    assign div_req.last     = b_li_reg;
    assign div_ack          = div_rsp.valid && out_free;

    mmar_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .ack     (div_ack),
        .rsp     (div_rsp)
    );

    // output register
    assign b_out_load = b_go && b_lr_reg && !is_mean;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (div_ack || b_out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ack) begin
            out_data_reg <= div_rsp.quotient;
            out_last_reg <= div_rsp.last;
        end else if (b_out_load) begin
            out_data_reg <= acc;
            out_last_reg <= b_li_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `MMAR_ASSERT_IMPL(a_div_idle_on_start, div_req.valid, !div_rsp.busy, "divider start while busy")
    `MMAR_ASSERT_NEXT(a_fwd_on_hit, accept && b_go && b_ip_reg == ipos_reg, b_fwd_reg, "no fwd")
    `MMAR_ASSERT_NEXT(a_accept_fills_stage, accept, b_valid_reg, "accepted beat lost")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-mode axis reducer. Streams tensor elements
// through the input port under every mode and several shapes, including zero
// and oversized lengths and the full 1024-position row. A bit-accurate model
// of the accumulators predicts each reduced beat and its row marker. Random
// gaps and stalls are applied on both streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmar_pkg::*;

    localparam logic [CFG_AW-1:0] REG_SPARE     = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int                TAIL_CYCLES   = 40;
    localparam int                ELEMENT_GOAL  = 1800;
    localparam int unsigned       CYCLE_LIMIT   = 1_500_000;

    localparam logic [DATA_WIDTH-1:0] EXTREMES [5] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    // two elements per mode, in mode order
    localparam logic [DATA_WIDTH-1:0] PAIRS [16] = '{
        32'h7FFF_FFFF, 32'h0000_0001,
        32'h8000_0000, 32'h0000_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF,
        32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h1234_5678, 32'hEDCB_A988
    };

    typedef struct packed {
        logic [DATA_WIDTH-1:0] reduced;
        logic                  row_done;
    } reduced_beat_t;

    class reduction_tracker;
        logic [MODE_W-1:0]     mode_q;
        logic [RLEN_W-1:0]     rlen_q;
        logic [ILEN_W-1:0]     ilen_q;
        int unsigned           red_pos;
        int unsigned           in_pos;
        logic [DATA_WIDTH-1:0] partial [MAX_INNER_DEF];
        reduced_beat_t         awaited [$];
        int                    fails;

        function new();
            mode_q  = MODE_SUM;
            rlen_q  = 1;
            ilen_q  = 1;
            red_pos = 0;
            in_pos  = 0;
            fails   = 0;
        endfunction

        function void note_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
            case (addr)
                REG_MODE:       mode_q = data[MODE_W-1:0];
                REG_REDUCE_LEN: rlen_q = data[RLEN_W-1:0];
                REG_INNER_LEN:  ilen_q = data[ILEN_W-1:0];
                default:        return;
            endcase
            red_pos = 0;
            in_pos  = 0;
        endfunction

        function void note_element(logic [DATA_WIDTH-1:0] x);
            int unsigned           rl, il, ip, rp;
            logic [DATA_WIDTH-1:0] v, p, acc, res;
            reduced_beat_t         beat;
            rl = (rlen_q == 0) ? 1 : rlen_q;
            il = (ilen_q == 0) ? 1 : ((ilen_q > MAX_INNER_DEF) ? MAX_INNER_DEF : ilen_q);
            ip = (in_pos < il) ? in_pos : il - 1;
            rp = (red_pos < rl) ? red_pos : rl - 1;
            v  = (mode_q == MODE_SSQ) ? x * x : x;
            p  = partial[ip];
            if (rp == 0) begin
                acc = v;
            end else begin
                case (mode_q)
                    MODE_PROD: acc = p * v;
                    MODE_MIN:  acc = ($signed(v) < $signed(p)) ? v : p;
                    MODE_MAX:  acc = ($signed(p) < $signed(v)) ? v : p;
                    default:   acc = p + v;
                endcase
            end
            partial[ip] = acc;
            if (rp + 1 == rl) begin
                if (mode_q == MODE_MEAN) begin
                    res = $signed(acc) / int'(rl);
                end else begin
                    res = acc;
                end
                beat.reduced  = res;
                beat.row_done = (ip + 1 == il);
                awaited.push_back(beat);
            end
            if (ip + 1 == il) begin
                in_pos  = 0;
                red_pos = (rp + 1 == rl) ? 0 : rp + 1;
            end else begin
                in_pos  = ip + 1;
                red_pos = rp;
            end
        endfunction

        function void check_reduced(logic [DATA_WIDTH-1:0] data, logic row_done);
            reduced_beat_t want;
            if (awaited.size() == 0) begin
                $error("unexpected beat: reduced %h row_done %b", data, row_done);
                fails++;
                return;
            end
            want = awaited.pop_front();
            if (data !== want.reduced) begin
                $error("reduced: expected %h actual %h", want.reduced, data);
                fails++;
            end
            if (row_done !== want.row_done) begin
                $error("row_done: expected %b actual %b", want.row_done, row_done);
                fails++;
            end
        endfunction

        function void flag_leftover();
            if (awaited.size() != 0) begin
                $error("%0d reduced beats never arrived", awaited.size());
                fails++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_AW-1:0]     cfg_addr;
    logic [CFG_DW-1:0]     cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_WIDTH-1:0] s_axis_tdata;    // [31:0] value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_WIDTH-1:0] m_axis_tdata;    // [31:0] reduced
    logic                  m_axis_tlast;

    reduction_tracker sb;
    int unsigned      cycle_count = 0;
    int               elements_sent = 0;
    logic             tx_calm;
    logic             rx_calm;

    multi_mode_axis_reducer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_axis_tvalid && m_axis_tready) begin
            sb.check_reduced(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int                    r;
        logic [DATA_WIDTH-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 15) return EXTREMES[$urandom_range(0, 4)];
        if (r < 45) begin
            s = DATA_WIDTH'($urandom_range(0, 16));
            return s - 32'd8;
        end
        return $urandom();
    endfunction

    // stall the result stream
    initial begin : rx_side
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.note_write(addr, data);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] md, input logic [CFG_DW-1:0] rl,
                             input logic [CFG_DW-1:0] il);
        cfg_write(REG_MODE, CFG_DW'(md));
        cfg_write(REG_REDUCE_LEN, rl);
        cfg_write(REG_INNER_LEN, il);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_element(input logic [DATA_WIDTH-1:0] v);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_element(v);
        elements_sent++;
        @(negedge aclk);
    endtask

    task automatic hold_until_drained(input int tail);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() > 0) @(negedge aclk);
        repeat (tail + 1) @(negedge aclk);
    endtask

    task automatic random_phase();
        logic [MODE_W-1:0] md;
        logic [CFG_DW-1:0] rl, il;
        int unsigned       span, n, r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            rl = 0;
            il = CFG_DW'($urandom_range(1, 8));
        end else if (r < 14) begin
            rl = CFG_DW'($urandom_range(1, 4));
            il = 0;
        end else if (r < 19) begin
            rl = CFG_DW'($urandom_range(100, 255));
            il = CFG_DW'($urandom_range(1, 2));
        end else if (r < 35) begin
            rl = CFG_DW'($urandom_range(6, 20));
            il = CFG_DW'($urandom_range(4, 24));
        end else begin
            rl = CFG_DW'($urandom_range(1, 5));
            il = CFG_DW'($urandom_range(1, 8));
        end
        span = ((rl == 0) ? 1 : rl) * ((il == 0) ? 1 : il);
        n    = span * $urandom_range(1, 3);
        if (n > 480) n = span;
        if ($urandom_range(0, 4) == 0) n += $urandom_range(1, span);
        md      = MODE_W'($urandom_range(MODE_SUM, MODE_SPARE_HI));
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        configure(md, rl, il);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 && $urandom_range(0, 3) == 0) hold_until_drained(0);
            send_element(pick_value());
        end
        hold_until_drained(TAIL_CYCLES);
    endtask

    task automatic wide_phases();
        logic [MODE_W-1:0] md;
        md = MODE_W'($urandom_range(MODE_SUM, MODE_SPARE_HI));
        configure(md, 1, 16'hFFFF);
        for (int i = 0; i < MAX_INNER_DEF; i++) begin
            if (i == MAX_INNER_DEF / 2) hold_until_drained(0);
            send_element(pick_value());
        end
        hold_until_drained(TAIL_CYCLES);
        configure(md, 1, MAX_INNER_DEF);
        for (int i = 0; i < 40; i++) send_element(pick_value());
        hold_until_drained(TAIL_CYCLES);
        configure(MODE_MEAN, 16'hFFFF, 1);
        for (int i = 0; i < 25; i++) send_element(pick_value());
        hold_until_drained(TAIL_CYCLES);
    endtask

    initial begin
        int phase_count;
        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_MODE;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        phase_count   = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        hold_until_drained(TAIL_CYCLES);
        for (int m = MODE_SUM; m <= MODE_SPARE_HI; m++) begin
            configure(m[MODE_W-1:0], 2, 1);
            send_element(PAIRS[2 * m]);
            send_element(PAIRS[2 * m + 1]);
            hold_until_drained(TAIL_CYCLES);
        end
        configure(MODE_MEAN, 3, 1);
        send_element(32'hFFFF_FFF9);
        send_element(32'h0000_0000);
        send_element(32'h0000_0000);
        hold_until_drained(TAIL_CYCLES);
        configure(MODE_MEAN, 0, 1);
        send_element(32'hFFFF_FFFB);
        hold_until_drained(TAIL_CYCLES);
        configure(MODE_MAX, 1, 0);
        send_element(32'h8000_0000);
        hold_until_drained(TAIL_CYCLES);
        configure(MODE_SUM, 2, 1);
        send_element(32'h0000_0005);
        hold_until_drained(TAIL_CYCLES);
        cfg_write(REG_SPARE, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        send_element(32'h0000_0007);
        hold_until_drained(TAIL_CYCLES);

        while (elements_sent < ELEMENT_GOAL) begin
            random_phase();
            phase_count++;
            if (phase_count == 6) wide_phases();
        end

        hold_until_drained(TAIL_CYCLES);
        sb.flag_leftover();
        if (sb.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/mmar_pkg.sv
sv/mmar_partials.sv
sv/mmar_div.sv
sv/multi_mode_axis_reducer_top.sv
tb/sv/tb.sv
